/* src/tdcf_pkg.sv */
// tdcf_pkg: types, constants and helper functions for the text display cell formatter
// no dependencies; used by the interfaces, the shared subtract unit and the top level

package tdcf_pkg;

  // payload widths fixed by the command and result formats
  localparam int OP_W   = 3;
  localparam int POS_W  = 5;
  localparam int CHAR_W = 8;
  localparam int WORD_W = 32;

  // default display size and width of the shared subtract unit
  localparam int CELL_COUNT_DEF = 32;
  localparam int ACC_W          = 9;

  // command codes
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_SETPOS = 3'd1,
    OP_CHAR   = 3'd2,
    OP_HEX    = 3'd3,
    OP_DEC    = 3'd4,
    OP_WORD   = 3'd5
  } op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_HUND,
    ST_TENS,
    ST_ADV,
    ST_EMIT,
    ST_CLEAR,
    ST_ONE
  } state_t;

  // character constants
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd48;
  localparam logic [CHAR_W-1:0] ALPHA_BASE = 8'd55;
  localparam logic [ACC_W-1:0]  HUNDRED    = 9'd100;
  localparam logic [ACC_W-1:0]  TEN        = 9'd10;

  // one nibble to an uppercase ascii hex digit
  function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] nib);
    logic [CHAR_W-1:0] ext;
    ext = {4'd0, nib};
    if (nib < 4'd10) begin
      return ext + DIGIT_BASE;
    end else begin
      return ext + ALPHA_BASE;
    end
  endfunction

  // decimal digit to ascii
  function automatic logic [CHAR_W-1:0] dec_digit(input logic [3:0] dig);
    return {4'd0, dig} + DIGIT_BASE;
  endfunction

endpackage

/* src/tdcf_if.sv */
// tdcf channel interfaces: command, result and configuration channels
// depends on tdcf_pkg for payload widths

interface tdcf_in_if;
  logic                        valid;
  logic                        ready;
  logic [tdcf_pkg::OP_W-1:0]   operation;
  logic [tdcf_pkg::CHAR_W-1:0] byte_value;
  logic [tdcf_pkg::WORD_W-1:0] word_value;
  logic [tdcf_pkg::POS_W-1:0]  new_position;

  modport source (output valid, operation, byte_value, word_value, new_position,
                  input ready);
  modport sink   (input valid, operation, byte_value, word_value, new_position,
                  output ready);
endinterface

interface tdcf_out_if;
  logic                        valid;
  logic                        ready;
  logic                        write_valid;
  logic [tdcf_pkg::POS_W-1:0]  cell_index;
  logic [tdcf_pkg::CHAR_W-1:0] cell_char;
  logic                        last_of_run;
  logic [tdcf_pkg::POS_W-1:0]  cursor_after;

  modport source (output valid, write_valid, cell_index, cell_char, last_of_run,
                  cursor_after, input ready);
  modport sink   (input valid, write_valid, cell_index, cell_char, last_of_run,
                  cursor_after, output ready);
endinterface

interface tdcf_cfg_if;
  logic valid;
  logic ready;
  logic auto_advance;

  modport source (output valid, auto_advance, input ready);
  modport sink   (input valid, auto_advance, output ready);
endinterface

/* src/tdcf_sub_unit.sv */
// tdcf_sub_unit: shared compare and subtract unit used by the sequencer
// depends on tdcf_pkg for the default operand width

module tdcf_sub_unit #(
  parameter int W = tdcf_pkg::ACC_W
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  logic [W:0] full;

  // one subtract, the borrow gives the compare
  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[W-1:0];
  assign ge   = ~full[W];

endmodule

/* src/text_display_cell_formatter_unit.sv */
// text_display_cell_formatter_unit: cursor keeper and command to cell-write sequencer
// depends on tdcf_pkg, tdcf_if and tdcf_sub_unit
//
//  channel   direction  handshake      payload
//  in_chan   sink       valid/ready    operation, byte_value, word_value, new_position
//  out_chan  source     valid/ready    write_valid, cell_index, cell_char, last_of_run,
//                                      cursor_after
//  cfg_chan  sink       valid/ready    auto_advance (ready always high)
//
// one command at a time; in_chan.ready is high only while the sequencer is idle
// char, hex and word make n = 1, 2 or 4 writes; clear writes a space to every cell
// decimal finds hundreds and tens digits by repeated subtraction and drops leading zeros
// set position (new_position mod CELL_COUNT) and other codes give one non-writing result
// one shared subtract unit; one result per cycle on out_chan unless out_chan stalls
// out_chan stalls hold the sequencer; synchronous active-low reset homes the cursor

module text_display_cell_formatter_unit #(
  parameter int CELL_COUNT = tdcf_pkg::CELL_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  tdcf_in_if.sink          in_chan,
  tdcf_out_if.source       out_chan,
  tdcf_cfg_if.sink         cfg_chan
);

  localparam int CW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int AW = tdcf_pkg::ACC_W;
  localparam int PW = tdcf_pkg::POS_W;
  localparam int BW = tdcf_pkg::CHAR_W;
  localparam logic [CW-1:0] LAST_CELL = CW'(CELL_COUNT - 1);
  localparam logic [AW-1:0] CELLS     = AW'(CELL_COUNT);

  // sequencer and datapath registers
  tdcf_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [1:0]    hund_r, hund_nxt;
  logic [3:0]    tens_r, tens_nxt;
  logic [BW-1:0] chars_r [4];
  logic [BW-1:0] chars_nxt [4];
  logic [2:0]    cnt_r, cnt_nxt;
  logic [1:0]    k_r, k_nxt;
  logic          auto_r;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_wv_r, out_wv_nxt;
  logic [PW-1:0] out_idx_r, out_idx_nxt;
  logic [BW-1:0] out_char_r, out_char_nxt;
  logic          out_last_r, out_last_nxt;
  logic [PW-1:0] out_after_r, out_after_nxt;

  // shared unit
  logic [AW-1:0] unit_a, unit_b, unit_diff;
  logic          unit_ge;

  logic accept;
  logic slot_free;
  logic [CW-1:0] idx_inc;
  logic emit_last;

  tdcf_sub_unit #(.W(AW)) u_sub (
    .a    (unit_a),
    .b    (unit_b),
    .diff (unit_diff),
    .ge   (unit_ge)
  );

  assign in_chan.ready = (state_r == tdcf_pkg::ST_IDLE);
  assign accept        = in_chan.valid & in_chan.ready;
  assign slot_free     = ~out_valid_r | out_chan.ready;
  assign idx_inc       = (idx_r == LAST_CELL) ? '0 : idx_r + CW'(1);
  assign emit_last     = (k_r == 2'(cnt_r - 3'd1));

  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.write_valid  = out_wv_r;
  assign out_chan.cell_index   = out_idx_r;
  assign out_chan.cell_char    = out_char_r;
  assign out_chan.last_of_run  = out_last_r;
  assign out_chan.cursor_after = out_after_r;

  // next state, shared unit operands and result loading
  always_comb begin
    state_nxt  = state_r;
    cursor_nxt = cursor_r;
    idx_nxt    = idx_r;
    acc_nxt    = acc_r;
    hund_nxt   = hund_r;
    tens_nxt   = tens_r;
    for (int i = 0; i < 4; i++) chars_nxt[i] = chars_r[i];
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    unit_a     = acc_r;
    unit_b     = CELLS;

    out_valid_nxt = out_valid_r & ~out_chan.ready;
    out_wv_nxt    = out_wv_r;
    out_idx_nxt   = out_idx_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_after_nxt = out_after_r;

    case (state_r)
      tdcf_pkg::ST_IDLE: begin
        if (accept) begin
          idx_nxt = cursor_r;
          k_nxt   = '0;
          case (tdcf_pkg::op_t'(in_chan.operation))
            tdcf_pkg::OP_CLEAR: begin
              cursor_nxt = '0;
              idx_nxt    = '0;
              state_nxt  = tdcf_pkg::ST_CLEAR;
            end
            tdcf_pkg::OP_SETPOS: begin
              acc_nxt   = AW'(in_chan.new_position);
              state_nxt = tdcf_pkg::ST_MOD;
            end
            tdcf_pkg::OP_CHAR: begin
              chars_nxt[0] = in_chan.byte_value;
              cnt_nxt      = 3'd1;
              state_nxt    = tdcf_pkg::ST_ADV;
            end
            tdcf_pkg::OP_HEX: begin
              chars_nxt[0] = tdcf_pkg::hex_digit(in_chan.byte_value[7:4]);
              chars_nxt[1] = tdcf_pkg::hex_digit(in_chan.byte_value[3:0]);
              cnt_nxt      = 3'd2;
              state_nxt    = tdcf_pkg::ST_ADV;
            end
            tdcf_pkg::OP_DEC: begin
              acc_nxt   = AW'(in_chan.byte_value);
              hund_nxt  = '0;
              tens_nxt  = '0;
              state_nxt = tdcf_pkg::ST_HUND;
            end
            tdcf_pkg::OP_WORD: begin
              chars_nxt[0] = in_chan.word_value[31:24];
              chars_nxt[1] = in_chan.word_value[23:16];
              chars_nxt[2] = in_chan.word_value[15:8];
              chars_nxt[3] = in_chan.word_value[7:0];
              cnt_nxt      = 3'd4;
              state_nxt    = tdcf_pkg::ST_ADV;
            end
            default: begin
              state_nxt = tdcf_pkg::ST_ONE;
            end
          endcase
        end
      end

      // new position reduced modulo the cell count
      tdcf_pkg::ST_MOD: begin
        unit_a = acc_r;
        unit_b = CELLS;
        if (unit_ge) begin
          acc_nxt = unit_diff;
        end else begin
          cursor_nxt = CW'(acc_r);
          state_nxt  = tdcf_pkg::ST_ONE;
        end
      end

      // hundreds digit by repeated subtraction
      tdcf_pkg::ST_HUND: begin
        unit_a = acc_r;
        unit_b = tdcf_pkg::HUNDRED;
        if (unit_ge) begin
          acc_nxt  = unit_diff;
          hund_nxt = hund_r + 2'd1;
        end else begin
          state_nxt = tdcf_pkg::ST_TENS;
        end
      end

      // tens digit, then leading-zero suppression
      tdcf_pkg::ST_TENS: begin
        unit_a = acc_r;
        unit_b = tdcf_pkg::TEN;
        if (unit_ge) begin
          acc_nxt  = unit_diff;
          tens_nxt = tens_r + 4'd1;
        end else begin
          state_nxt = tdcf_pkg::ST_ADV;
          if (hund_r != 2'd0) begin
            chars_nxt[0] = tdcf_pkg::dec_digit({2'd0, hund_r});
            chars_nxt[1] = tdcf_pkg::dec_digit(tens_r);
            chars_nxt[2] = tdcf_pkg::dec_digit(acc_r[3:0]);
            cnt_nxt      = 3'd3;
          end else if (tens_r != 4'd0) begin
            chars_nxt[0] = tdcf_pkg::dec_digit(tens_r);
            chars_nxt[1] = tdcf_pkg::dec_digit(acc_r[3:0]);
            cnt_nxt      = 3'd2;
          end else begin
            chars_nxt[0] = tdcf_pkg::dec_digit(acc_r[3:0]);
            cnt_nxt      = 3'd1;
          end
        end
      end

      // cursor advance by the write count when auto_advance is set, with one wrap
      tdcf_pkg::ST_ADV: begin
        unit_a = AW'(cursor_r) + (auto_r ? AW'(cnt_r) : '0);
        unit_b = CELLS;
        cursor_nxt = unit_ge ? CW'(unit_diff) : CW'(unit_a);
        state_nxt  = tdcf_pkg::ST_EMIT;
      end

      // one character write per free output slot
      tdcf_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_wv_nxt    = 1'b1;
          out_idx_nxt   = PW'(idx_r);
          out_char_nxt  = chars_r[k_r];
          out_last_nxt  = emit_last;
          out_after_nxt = PW'(cursor_r);
          idx_nxt       = idx_inc;
          k_nxt         = k_r + 2'd1;
          if (emit_last) begin
            state_nxt = tdcf_pkg::ST_IDLE;
          end
        end
      end

      // space to every cell in order
      tdcf_pkg::ST_CLEAR: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_wv_nxt    = 1'b1;
          out_idx_nxt   = PW'(idx_r);
          out_char_nxt  = tdcf_pkg::SPACE_CHAR;
          out_last_nxt  = (idx_r == LAST_CELL);
          out_after_nxt = '0;
          idx_nxt       = idx_inc;
          if (idx_r == LAST_CELL) begin
            state_nxt = tdcf_pkg::ST_IDLE;
          end
        end
      end

      // single non-writing result
      tdcf_pkg::ST_ONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_wv_nxt    = 1'b0;
          out_idx_nxt   = '0;
          out_char_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_after_nxt = PW'(cursor_r);
          state_nxt     = tdcf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tdcf_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdcf_pkg::ST_IDLE;
      cursor_r    <= '0;
      auto_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        auto_r <= cfg_chan.auto_advance;
      end
    end
  end

  // datapath and result payload registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    acc_r       <= acc_nxt;
    hund_r      <= hund_nxt;
    tens_r      <= tens_nxt;
    for (int i = 0; i < 4; i++) chars_r[i] <= chars_nxt[i];
    cnt_r       <= cnt_nxt;
    k_r         <= k_nxt;
    out_wv_r    <= out_wv_nxt;
    out_idx_r   <= out_idx_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_after_r <= out_after_nxt;
  end

endmodule

/* src/tdcf_checker.sv */
// tdcf_checker: port-level checks on the text display cell formatter
// depends on text_display_cell_formatter_unit, to which it is bound below

module tdcf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       write_valid,
  input logic [4:0] cell_index,
  input logic [7:0] cell_char,
  input logic       last_of_run,
  input logic [4:0] cursor_after
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cell_index) && $stable(cell_char)
      && $stable(write_valid) && $stable(last_of_run) && $stable(cursor_after))
    else $error("result changed while stalled");

  // one command at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new request taken while busy");

  // non-writing result is a lone, zeroed, final result
  a_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !write_valid |-> last_of_run && cell_index == 5'd0 && cell_char == 8'd0)
    else $error("malformed non-writing result");

  // a run continues back to back with the same cursor
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_of_run |=> out_valid && write_valid
      && cursor_after == $past(cursor_after))
    else $error("run broken or cursor changed within run");

endmodule

bind text_display_cell_formatter_unit tdcf_checker u_tdcf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .write_valid  (out_chan.write_valid),
  .cell_index   (out_chan.cell_index),
  .cell_char    (out_chan.cell_char),
  .last_of_run  (out_chan.last_of_run),
  .cursor_after (out_chan.cursor_after)
);
